// File: sv/bitmap_block_pool_allocator_defines.svh
// Assertion macros used by the allocator back end.
`ifndef BITMAP_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BBPA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBPA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/bbpa_pkg.sv
// Types and constants shared by the block pool allocator.
package bbpa_pkg;
    localparam int MAX_BLOCKS = 1024;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int WIDX_W     = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int QUE_DEPTH  = 2;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
    localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;
    localparam logic [1:0] REG_POOL_BASE   = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] block_address;
        logic [9:0]  block_index;
        logic        in_pool;
        logic [10:0] used_blocks;
        logic [31:0] missed_allocs;
    } rsp_t;

    // Classified work handed from the front to the back.
    typedef struct packed {
        logic [1:0]  cmd;
        logic        hit;
        logic [IDX_W-1:0] index;
    } job_t;
endpackage

// File: sv/bbpa_front.sv
// Front end: for a free or query, divides the address offset by the block size; classifies every request.
module bbpa_front
    import bbpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  req_t        req,
    input  logic [15:0] block_size,
    input  logic [10:0] block_count,
    input  logic [31:0] pool_base,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic        ge_reg, ge_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] off_reg, off_next;
    logic [15:0] size_eff;
    logic [10:0] count_eff;
    logic [32:0] rem_sh;
    logic        hit;

    assign size_eff  = (block_size == 16'd0) ? 16'd1 : block_size;
    assign count_eff = (block_count > 11'(MAX_BLOCKS)) ? 11'(MAX_BLOCKS) : block_count;
    assign full      = (state_reg != ST_IDLE);
    assign job_valid = (state_reg == ST_OUT);
    assign rem_sh    = {rem_reg[31:0], off_reg[31]};

    // A query hits when off <= size*(count-1). With off = quo*size + rem this holds
    // exactly when quo < count-1, or when quo == count-1 and there is no remainder.
    always_comb
    begin
        hit = 1'b0;
        case (cmd_reg)
            CMD_FREE:  hit = ge_reg && (quo_reg < 32'(count_eff));
            CMD_QUERY: hit = ge_reg && (count_eff != 11'd0) &&
                             ((quo_reg < 32'(count_eff - 11'd1)) ||
                              ((quo_reg == 32'(count_eff - 11'd1)) && (rem_reg == 33'd0)));
            default:   hit = 1'b0;
        endcase
    end

    assign job.cmd   = cmd_reg;
    assign job.hit   = hit;
    assign job.index = quo_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        ge_next    = ge_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        off_next   = off_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    cmd_next = req.cmd;
                    ge_next  = (req.address >= pool_base);
                    off_next = req.address - pool_base;
                    quo_next = 32'd0;
                    rem_next = 33'd0;
                    step_next = 6'd0;
                    state_next = (req.cmd == CMD_FREE || req.cmd == CMD_QUERY) ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle, restoring division.
                if (rem_sh >= 33'(size_eff))
                begin
                    rem_next = rem_sh - 33'(size_eff);
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                off_next  = {off_reg[30:0], 1'b0};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd31)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (job_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        cmd_reg  <= cmd_next;
        ge_reg   <= ge_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        off_reg  <= off_next;
    end
endmodule

// File: sv/bbpa_queue.sv
// Short request queue between the front and the back.
module bbpa_queue
    import bbpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);
    job_t       mem_reg [QUE_DEPTH];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_en, rd_en;

    assign wr_ready = (cnt_reg != 2'(QUE_DEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign cnt_next = cnt_reg + 2'(wr_en) - 2'(rd_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end
endmodule

// File: sv/bbpa_back.sv
// Back end: scans and updates the occupancy bitmap and forms each response.
`include "bitmap_block_pool_allocator_defines.svh"
module bbpa_back
    import bbpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    input  logic [15:0] block_size,
    input  logic [10:0] block_count,
    input  logic [31:0] pool_base,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_FREE = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [WORD_BITS-1:0] map_reg [MAP_WORDS];
    logic [MAP_WORDS-1:0] wvalid_reg;
    logic [WIDX_W:0] wp_reg, wp_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [31:0] miss_reg, miss_next;
    logic [31:0] prod_reg, prod_next;
    logic        ok_reg, ok_next, inpool_reg, inpool_next;
    logic [1:0]  cmd_reg;
    logic        wr_en, wr_val;
    logic [IDX_W-1:0] wr_idx;
    logic [WORD_BITS-1:0] word, avail;
    logic [BIT_W-1:0] first;
    logic        any;
    logic [15:0] size_eff;
    logic [10:0] count_eff;
    logic [CNT_W-1:0] wbase;
    rsp_t        rsp_reg, rsp_next;
    logic        rsp_v_reg;

    assign size_eff  = (block_size == 16'd0) ? 16'd1 : block_size;
    assign count_eff = (block_count > 11'(MAX_BLOCKS)) ? 11'(MAX_BLOCKS) : block_count;
    assign word  = wvalid_reg[wp_reg[WIDX_W-1:0]] ? map_reg[wp_reg[WIDX_W-1:0]] : '0;
    assign wbase = CNT_W'(wp_reg) << BIT_W;

    // Free bits of the current word that also lie below the block count.
    always_comb
    begin
        avail = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            avail[b] = !word[b] && ((wbase + CNT_W'(b)) < CNT_W'(count_eff));
        end
        any   = |avail;
        first = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b]) first = BIT_W'(b);
        end
    end

    assign job_ready = (state_reg == ST_IDLE) && !rsp_v_reg;
    assign rsp_valid = rsp_v_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        miss_next  = miss_reg;
        prod_next  = prod_reg;
        ok_next    = ok_reg;
        inpool_next = inpool_reg;
        wr_en  = 1'b0;
        wr_val = 1'b0;
        wr_idx = idx_reg;
        rsp_next = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && job_ready)
                begin
                    idx_next    = job.index;
                    ok_next     = 1'b0;
                    inpool_next = 1'b0;
                    wp_next     = '0;
                    case (job.cmd)
                        CMD_ALLOC: state_next = ST_SCAN;
                        CMD_FREE:  state_next = job.hit ? ST_FREE : ST_DONE;
                        CMD_QUERY:
                        begin
                            inpool_next = job.hit;
                            state_next  = ST_DONE;
                        end
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (any)
                begin
                    idx_next   = IDX_W'({wp_reg, first});
                    ok_next    = 1'b1;
                    state_next = ST_MUL;
                end
                else if ((wp_reg == (WIDX_W+1)'(MAP_WORDS - 1)) ||
                         (wbase + CNT_W'(WORD_BITS) >= CNT_W'(count_eff)))
                begin
                    miss_next  = miss_reg + 32'd1;
                    state_next = ST_DONE;
                end
                else
                begin
                    wp_next = wp_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                wr_en      = 1'b1;
                wr_val     = 1'b1;
                used_next  = used_reg + CNT_W'(1);
                prod_next  = 32'(idx_reg) * 32'(size_eff);
                state_next = ST_DONE;
            end
            ST_FREE:
            begin
                wr_en      = 1'b1;
                wr_val     = 1'b0;
                ok_next    = 1'b1;
                if (used_reg != '0) used_next = used_reg - CNT_W'(1);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                rsp_next.ok            = ok_reg;
                rsp_next.block_address = (ok_reg && cmd_reg == CMD_ALLOC) ?
                                         pool_base + prod_reg : 32'd0;
                rsp_next.block_index   = ok_reg ? 10'(idx_reg) : 10'd0;
                rsp_next.in_pool       = inpool_reg;
                rsp_next.used_blocks   = 11'(used_reg);
                rsp_next.missed_allocs = miss_reg;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wvalid_reg <= '0;
            used_reg   <= '0;
            miss_reg   <= '0;
            rsp_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            miss_reg  <= miss_next;
            if (wr_en) wvalid_reg[wr_idx[IDX_W-1:BIT_W]] <= 1'b1;
            if (state_reg == ST_DONE) rsp_v_reg <= 1'b1;
            else if (rsp_ready) rsp_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        wp_reg     <= wp_next;
        idx_reg    <= idx_next;
        prod_reg   <= prod_next;
        ok_reg     <= ok_next;
        inpool_reg <= inpool_next;
        rsp_reg    <= rsp_next;
        if (job_valid && job_ready) cmd_reg <= job.cmd;
        if (wr_en)
        begin
            map_reg[wr_idx[IDX_W-1:BIT_W]] <= wvalid_reg[wr_idx[IDX_W-1:BIT_W]] ?
                (map_reg[wr_idx[IDX_W-1:BIT_W]] & ~(WORD_BITS'(1) << wr_idx[BIT_W-1:0])) |
                (WORD_BITS'(wr_val) << wr_idx[BIT_W-1:0]) :
                (WORD_BITS'(wr_val) << wr_idx[BIT_W-1:0]);
        end
    end

    `BBPA_ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1, used_reg <= CNT_W'(MAX_BLOCKS), "used count overflow")
    `BBPA_ASSERT_NEXT(a_miss_step, clk, rst_n, state_reg == ST_SCAN && !any && state_next == ST_DONE, miss_reg == $past(miss_reg) + 32'd1, "miss not counted")
    `BBPA_ASSERT_NEXT(a_alloc_used, clk, rst_n, state_reg == ST_MUL, used_reg == $past(used_reg) + CNT_W'(1), "alloc not counted")
    `BBPA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, rsp_v_reg, !job_ready, "job taken while response pending")
endmodule

// File: sv/bitmap_block_pool_allocator.sv
// Top level of the bitmap block pool allocator.
// A free or query runs a 32-step restoring divide of the address offset by the block
// size in the front end, which takes no new request until it has handed its job to
// the queue. An allocate skips the divide in the front end and then scans one bitmap
// word per cycle in the back end, up to 32 words, before its response is formed.
// Each end works on one request at a time; the back end waits while a response is not
// popped. Configuration may only be written while no request is in flight.
module bitmap_block_pool_allocator
    import bbpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  req_t        req,
    output logic        empty,
    input  logic        pop,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [15:0] size_reg;
    logic [10:0] count_reg;
    logic [31:0] base_reg;
    logic        fj_valid, fj_ready, bj_valid, bj_ready, rsp_valid;
    job_t        fj, bj;

    assign cfg_ready = 1'b1;
    assign empty     = !rsp_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= 16'd16;
            count_reg <= 11'd1024;
            base_reg  <= 32'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE:  size_reg  <= cfg_data[15:0];
                REG_BLOCK_COUNT: count_reg <= cfg_data[10:0];
                REG_POOL_BASE:   base_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    bbpa_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .block_size(size_reg), .block_count(count_reg), .pool_base(base_reg),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    bbpa_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    bbpa_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .block_size(size_reg), .block_count(count_reg), .pool_base(base_reg),
        .rsp_valid(rsp_valid), .rsp_ready(pop), .rsp(rsp)
    );
endmodule
